// ===== rtl/tle_pkg.sv =====
package tle_pkg;

	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_GT  = 8'h3E;
	localparam logic [7:0] CH_LBR = 8'h5B;
	localparam logic [7:0] CH_A   = 8'h41;
	localparam logic [7:0] CH_C   = 8'h43;
	localparam logic [7:0] CH_D   = 8'h44;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_GOT  = 2'd1,
		ESC_BRK  = 2'd2,
		ESC_SPARE = 2'd3
	} esc_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       to_line;
		logic       last;
	} res_t;

endpackage

// ===== rtl/tle_if.sv =====
interface tle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	modport source (output valid, output in_char, input ready);
	modport sink   (input valid, input in_char, output ready);
endinterface

interface tle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       to_line;
	logic       last;
	modport source (output valid, output out_byte, output to_line, output last, input ready);
	modport sink   (input valid, input out_byte, input to_line, input last, output ready);
endinterface

interface tle_cfg_if;
	logic valid;
	logic ready;
	logic echo_enable;
	modport source (output valid, output echo_enable, input ready);
	modport sink   (input valid, input echo_enable, output ready);
endinterface

// ===== rtl/terminal_line_editor_unit.sv =====
// Terminal line editor. Takes received terminal bytes one item at a time on
// in_ch and emits echo, bell, cursor and repaint bytes (to_line=0) and, on
// carriage return, the finished line (to_line=1) on out_ch; last marks the
// final result of each input byte. The line and the one-entry history live
// in two synchronous RAMs of LINE_CAPACITY bytes. Each item is first accepted
// and decoded; each moved or copied byte is then read and written back: an
// insert or delete shifts the line, a recall copies the history, and enter
// reads each line byte and writes it to the history while emitting it.
// Repaint reads the line one byte per cycle while the output takes bytes.
// Configuration is taken at any time the port is valid; write echo_enable
// only while the block is idle.
module terminal_line_editor_unit #(
	parameter int LINE_CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	tle_cfg_if.sink   cfg,
	tle_in_if.sink    in_ch,
	tle_out_if.source out_ch
);
	import tle_pkg::*;

	localparam int AW = $clog2(LINE_CAPACITY);
	localparam int LW = $clog2(LINE_CAPACITY + 2);
	localparam logic [LW-1:0] CAP = LW'(LINE_CAPACITY);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SHIFT = 9'b000000010, // insert: move bytes right
		ST_CLOSE = 9'b000000100, // delete: move bytes left
		ST_COPYH = 9'b000001000, // recall: history -> line
		ST_COPYL = 9'b000010000, // enter: line -> history and output
		ST_PROMPT = 9'b000100000, // CR > space
		ST_PAINT = 9'b001000000, // line bytes
		ST_TAIL  = 9'b010000000, // trailing space / backspaces
		ST_EMIT  = 9'b100000000  // short fixed sequence
	} state_t;

	state_t st_q;
	esc_t   esc_q;
	logic   echo_q;
	logic [LW-1:0] len_q, cur_q, rlen_q, idx_q, cnt_q;
	logic [1:0] sub_q;        // phase inside a step / fixed sequence index
	logic [7:0] seq_q [3];
	logic [1:0] seq_n_q;
	logic       tail_sp_q;    // emit a space before the backspaces
	logic       rd_pend_q;

	// memories
	logic [7:0] line_mem [LINE_CAPACITY];
	logic [7:0] hist_mem [LINE_CAPACITY];
	logic [7:0] line_rd_q, hist_rd_q;
	logic       lwe, hwe;
	logic [AW-1:0] lwa, lra, hwa, hra;
	logic [7:0] lwd;

	always_ff @(posedge clk) begin
		if (lwe) line_mem[lwa] <= lwd;
		if (hwe) hist_mem[hwa] <= line_rd_q;
		line_rd_q <= line_mem[lra];
		hist_rd_q <= hist_mem[hra];
	end

	// output
	logic push, can_push;
	res_t pd;
	tle_out_reg u_out (.clk, .arst_n, .push, .push_data(pd), .can_push, .out(out_ch));

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) echo_q <= 1'b0;
		else if (cfg.valid) echo_q <= cfg.echo_enable;
	end

	logic [7:0] c;
	logic acc, printable;
	assign c = in_ch.in_char;
	assign acc = in_ch.valid && st_q == ST_IDLE;
	assign printable = c >= CH_SP && c < CH_DEL;

	// Combinational control: memory ports and output push.
	always_comb begin
		lwe = 1'b0; hwe = 1'b0; push = 1'b0;
		lwa = idx_q[AW-1:0]; lra = idx_q[AW-1:0];
		hwa = idx_q[AW-1:0]; hra = idx_q[AW-1:0];
		lwd = line_rd_q;
		pd  = '{out_byte: 8'h00, to_line: 1'b0, last: 1'b0};
		unique case (st_q)
			ST_IDLE: begin
				// end-of-line insert writes directly
				if (acc && esc_q != ESC_BRK && !(esc_q == ESC_GOT && c == CH_LBR)
				    && printable && len_q < CAP && cur_q == len_q) begin
					lwe = 1'b1; lwa = cur_q[AW-1:0]; lwd = c;
				end
			end
			ST_SHIFT: begin
				// sub 0: read idx-1; sub 1: write idx
				lra = AW'(idx_q - 1'b1);
				if (sub_q == 2'd1) begin
					lwe = 1'b1;
					if (idx_q == cur_q) lwd = seq_q[0];
				end
			end
			ST_CLOSE: begin
				lra = AW'(idx_q + 1'b1);
				if (sub_q == 2'd1) lwe = 1'b1;
			end
			ST_COPYH: begin
				if (sub_q == 2'd1) begin
					lwe = 1'b1; lwd = hist_rd_q;
				end
			end
			ST_COPYL: begin
				if (sub_q == 2'd1 && can_push) begin
					push = 1'b1;
					pd = '{out_byte: line_rd_q, to_line: 1'b1,
					       last: (idx_q + 1'b1 == len_q)};
					hwe = 1'b1;
				end
			end
			ST_PROMPT: begin
				lra = '0;
				if (can_push) begin
					push = 1'b1;
					pd.out_byte = (sub_q == 2'd0) ? CH_CR : (sub_q == 2'd1) ? CH_GT : CH_SP;
					pd.last = sub_q == 2'd2 && len_q == '0 && cnt_q == '0 && !tail_sp_q;
				end
			end
			ST_PAINT: begin
				if (rd_pend_q && can_push) begin
					push = 1'b1;
					pd.out_byte = line_rd_q;
					pd.last = (idx_q + 1'b1 == len_q) && cnt_q == '0 && !tail_sp_q;
				end
				if (rd_pend_q && can_push) lra = AW'(idx_q + 1'b1);
			end
			ST_TAIL: begin
				if (can_push) begin
					push = 1'b1;
					pd.out_byte = tail_sp_q ? CH_SP : CH_BS;
					pd.last = !tail_sp_q && cnt_q == LW'(1);
				end
			end
			ST_EMIT: begin
				if (can_push) begin
					push = 1'b1;
					pd.out_byte = seq_q[sub_q];
					// LF of enter is not last when line bytes follow
					pd.last = (sub_q + 1'b1 == seq_n_q)
					       && !(seq_q[0] == CH_CR && seq_n_q == 2'd2 && len_q != '0);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; esc_q <= ESC_NONE;
			len_q <= '0; cur_q <= '0; rlen_q <= '0;
			idx_q <= '0; cnt_q <= '0; sub_q <= '0; seq_n_q <= '0;
			tail_sp_q <= 1'b0; rd_pend_q <= 1'b0;
			seq_q[0] <= '0; seq_q[1] <= '0; seq_q[2] <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (acc) begin
					sub_q <= '0;
					if (esc_q == ESC_BRK) begin
						esc_q <= ESC_NONE;
						if (c == CH_A) begin
							len_q <= rlen_q; cur_q <= rlen_q;
							idx_q <= '0; cnt_q <= '0; tail_sp_q <= 1'b0;
							st_q <= (rlen_q == '0) ? ST_PROMPT : ST_COPYH;
						end else if (c == CH_C) begin
							st_q <= ST_EMIT;
							if (cur_q < len_q) begin
								cur_q <= cur_q + 1'b1;
								seq_q[0] <= CH_ESC; seq_q[1] <= CH_LBR; seq_q[2] <= CH_C;
								seq_n_q <= 2'd3;
							end else begin
								seq_q[0] <= CH_BEL; seq_n_q <= 2'd1;
							end
						end else if (c == CH_D) begin
							st_q <= ST_EMIT; seq_n_q <= 2'd1;
							if (cur_q != '0) begin
								cur_q <= cur_q - 1'b1; seq_q[0] <= CH_BS;
							end else seq_q[0] <= CH_BEL;
						end
					end else if (esc_q == ESC_GOT && c == CH_LBR) begin
						esc_q <= ESC_BRK;
					end else begin
						esc_q <= ESC_NONE;
						if (printable) begin
							if (len_q >= CAP) begin
								seq_q[0] <= CH_BEL; seq_n_q <= 2'd1; st_q <= ST_EMIT;
							end else if (cur_q == len_q) begin
								cur_q <= cur_q + 1'b1; len_q <= len_q + 1'b1;
								if (echo_q) begin
									seq_q[0] <= c; seq_n_q <= 2'd1; st_q <= ST_EMIT;
								end
							end else begin
								seq_q[0] <= c; idx_q <= len_q; st_q <= ST_SHIFT;
							end
						end else if (c == CH_CR) begin
							seq_q[0] <= CH_CR; seq_q[1] <= CH_LF;
							idx_q <= '0; st_q <= ST_EMIT; seq_n_q <= 2'd2;
							// ST_EMIT hands over to ST_COPYL when the line is non-empty
						end else if (c == CH_BS || c == CH_DEL) begin
							if (cur_q == '0) begin
								seq_q[0] <= CH_BEL; seq_n_q <= 2'd1; st_q <= ST_EMIT;
							end else if (cur_q == len_q) begin
								seq_q[0] <= CH_BS; seq_q[1] <= CH_SP; seq_q[2] <= CH_BS;
								seq_n_q <= 2'd3; st_q <= ST_EMIT;
								len_q <= len_q - 1'b1; cur_q <= cur_q - 1'b1;
							end else begin
								len_q <= len_q - 1'b1; cur_q <= cur_q - 1'b1;
								idx_q <= cur_q - 1'b1; st_q <= ST_CLOSE;
							end
						end else if (c == CH_ESC) begin
							esc_q <= ESC_GOT;
						end
					end
				end
				ST_SHIFT: begin
					if (sub_q == 2'd0) sub_q <= 2'd1;
					else begin
						sub_q <= 2'd0;
						if (idx_q == cur_q) begin
							cur_q <= cur_q + 1'b1; len_q <= len_q + 1'b1;
							if (echo_q) begin
								st_q <= ST_PROMPT; idx_q <= '0; tail_sp_q <= 1'b0;
								cnt_q <= len_q - cur_q;
							end else st_q <= ST_IDLE;
						end else idx_q <= idx_q - 1'b1;
					end
				end
				ST_CLOSE: begin
					if (idx_q == len_q) begin
						st_q <= ST_PROMPT; idx_q <= '0; sub_q <= '0; tail_sp_q <= 1'b1;
						cnt_q <= len_q - cur_q + 1'b1;
					end else if (sub_q == 2'd0) sub_q <= 2'd1;
					else begin
						sub_q <= 2'd0; idx_q <= idx_q + 1'b1;
					end
				end
				ST_COPYH: begin
					if (sub_q == 2'd0) sub_q <= 2'd1;
					else begin
						sub_q <= 2'd0;
						if (idx_q + 1'b1 == len_q) begin
							idx_q <= '0; st_q <= ST_PROMPT;
						end else idx_q <= idx_q + 1'b1;
					end
				end
				ST_COPYL: begin
					if (sub_q == 2'd0) sub_q <= 2'd1;
					else if (can_push) begin
						sub_q <= 2'd0;
						if (idx_q + 1'b1 == len_q) begin
							rlen_q <= len_q; len_q <= '0; cur_q <= '0;
							idx_q <= '0; st_q <= ST_IDLE;
						end else idx_q <= idx_q + 1'b1;
					end
				end
				ST_PROMPT: if (can_push) begin
					if (sub_q == 2'd2) begin
						sub_q <= '0; idx_q <= '0; rd_pend_q <= 1'b1;
						st_q <= (len_q != '0) ? ST_PAINT
						      : (cnt_q != '0 || tail_sp_q) ? ST_TAIL : ST_IDLE;
					end else sub_q <= sub_q + 1'b1;
				end
				ST_PAINT: if (can_push) begin
					if (idx_q + 1'b1 == len_q) begin
						rd_pend_q <= 1'b0;
						st_q <= (cnt_q != '0 || tail_sp_q) ? ST_TAIL : ST_IDLE;
					end else idx_q <= idx_q + 1'b1;
				end
				ST_TAIL: if (can_push) begin
					if (tail_sp_q) tail_sp_q <= 1'b0;
					else begin
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == LW'(1)) st_q <= ST_IDLE;
					end
				end
				ST_EMIT: if (can_push) begin
					if (sub_q + 1'b1 == seq_n_q) begin
						sub_q <= '0;
						// CR LF of enter continues with the line bytes
						if (seq_q[0] == CH_CR && seq_n_q == 2'd2 && len_q != '0) begin
							idx_q <= '0; st_q <= ST_COPYL;
						end else begin
							if (seq_q[0] == CH_CR && seq_n_q == 2'd2) begin
								len_q <= '0; cur_q <= '0;
							end
							st_q <= ST_IDLE;
						end
					end else sub_q <= sub_q + 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Enter with empty line must mark LF as last: seq_n_q=2, sub 1 -> last set above.
	// Unused read data when no push; keep hist read address tied to index.

endmodule

// ===== rtl/tle_out_reg.sv =====
// Output register with a one-entry skid stage.
module tle_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tle_pkg::res_t   push_data,
	output logic            can_push,
	tle_out_if.source       out
);
	import tle_pkg::*;

	res_t main_q, skid_q;
	logic main_vld_q, skid_vld_q;

	assign can_push     = !skid_vld_q;
	assign out.valid    = main_vld_q;
	assign out.out_byte = main_q.out_byte;
	assign out.to_line  = main_q.to_line;
	assign out.last     = main_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!main_vld_q || out.ready) begin
				if (skid_vld_q) begin
					main_vld_q <= 1'b1;
					skid_vld_q <= push;
				end else begin
					main_vld_q <= push;
				end
			end else if (push) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q || out.ready) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
				if (push) skid_q <= push_data;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

// ===== rtl/tle_checker.sv =====
module tle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       to_line,
	input logic       last
);
	import tle_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("stalled result changed");

	// line bytes are printable
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && to_line |-> out_byte >= CH_SP && out_byte < CH_DEL)
		else $error("non-printable line byte");

	// once a non-last line byte is taken, no terminal byte is offered right after it
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && to_line && !last |=> !(out_valid && !to_line))
		else $error("line output interrupted");
endmodule

bind terminal_line_editor_unit tle_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_byte(out_ch.out_byte), .to_line(out_ch.to_line), .last(out_ch.last)
);

// ===== sim/tb_terminal_line_editor_unit.sv =====
`timescale 1ns / 100ps

module tb_terminal_line_editor_unit;
	import tle_pkg::*;

	localparam int LINE_CAP  = 16;
	localparam int N_RANDOM  = 148;
	localparam int TAIL_IDLE = 3 * LINE_CAP + 20;

	logic clk;
	logic arst_n;

	tle_cfg_if cfg();
	tle_in_if  in_ch();
	tle_out_if out_ch();

	terminal_line_editor_unit #(.LINE_CAPACITY(LINE_CAP)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg.sink),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// Shadow copy of the editor state, advanced once per accepted item.
	esc_t       sh_esc;
	logic [7:0] sh_line [LINE_CAP];
	int         sh_len;
	int         sh_cur;
	logic [7:0] sh_hist [LINE_CAP];
	int         sh_hist_len;
	logic       sh_echo;

	res_t pending_bytes[$];
	int   n_pred;         // results predicted for the latest item
	int   mismatches;
	bit   rx_quiet;       // drop all receiver stalls near the end
	bit   rx_hold_req;    // ask the receiver for a long hold-off
	bit   tx_quiet;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	// Append one terminal or line byte to the expected stream.
	task automatic push_byte(input logic [7:0] b, input logic to_line);
		res_t r;
		r.out_byte = b;
		r.to_line  = to_line;
		r.last     = 1'b0;
		pending_bytes.push_back(r);
	endtask

	task automatic push_repaint();
		push_byte(CH_CR, 1'b0);
		push_byte(CH_GT, 1'b0);
		push_byte(CH_SP, 1'b0);
		for (int i = 0; i < sh_len; i++) push_byte(sh_line[i], 1'b0);
	endtask

	task automatic edit_escape_code(input logic [7:0] c);
		if (c == CH_A) begin
			for (int i = 0; i < sh_hist_len; i++) sh_line[i] = sh_hist[i];
			sh_len = sh_hist_len;
			sh_cur = sh_len;
			push_repaint();
		end else if (c == CH_C) begin
			if (sh_cur < sh_len) begin
				sh_cur++;
				push_byte(CH_ESC, 1'b0);
				push_byte(CH_LBR, 1'b0);
				push_byte(CH_C, 1'b0);
			end else begin
				push_byte(CH_BEL, 1'b0);
			end
		end else if (c == CH_D) begin
			if (sh_cur > 0) begin
				sh_cur--;
				push_byte(CH_BS, 1'b0);
			end else begin
				push_byte(CH_BEL, 1'b0);
			end
		end
	endtask

	task automatic edit_plain(input logic [7:0] c);
		if (c >= CH_SP && c < CH_DEL) begin
			if (sh_len >= LINE_CAP) begin
				push_byte(CH_BEL, 1'b0);
			end else if (sh_cur == sh_len) begin
				if (sh_echo) push_byte(c, 1'b0);
				sh_line[sh_cur] = c;
				sh_cur++;
				sh_len++;
			end else begin
				for (int i = sh_len; i > sh_cur; i--) sh_line[i] = sh_line[i-1];
				sh_line[sh_cur] = c;
				sh_cur++;
				sh_len++;
				if (sh_echo) begin
					push_repaint();
					for (int i = sh_cur; i < sh_len; i++) push_byte(CH_BS, 1'b0);
				end
			end
		end else if (c == CH_CR) begin
			push_byte(CH_CR, 1'b0);
			push_byte(CH_LF, 1'b0);
			for (int i = 0; i < sh_len; i++) push_byte(sh_line[i], 1'b1);
			if (sh_len > 0) begin
				for (int i = 0; i < sh_len; i++) sh_hist[i] = sh_line[i];
				sh_hist_len = sh_len;
			end
			sh_len = 0;
			sh_cur = 0;
		end else if (c == CH_BS || c == CH_DEL) begin
			if (sh_cur == 0) begin
				push_byte(CH_BEL, 1'b0);
			end else if (sh_cur == sh_len) begin
				push_byte(CH_BS, 1'b0);
				push_byte(CH_SP, 1'b0);
				push_byte(CH_BS, 1'b0);
				sh_len--;
				sh_cur--;
			end else begin
				sh_len--;
				sh_cur--;
				for (int i = sh_cur; i < sh_len; i++) sh_line[i] = sh_line[i+1];
				push_repaint();
				push_byte(CH_SP, 1'b0);
				for (int i = sh_cur; i < sh_len + 1; i++) push_byte(CH_BS, 1'b0);
			end
		end else if (c == CH_ESC) begin
			sh_esc = ESC_GOT;
		end
	endtask

	// Predict the output bytes of one accepted input byte.
	task automatic predict_edit(input logic [7:0] c);
		int base;
		base = pending_bytes.size();
		if (sh_esc == ESC_BRK) begin
			sh_esc = ESC_NONE;
			edit_escape_code(c);
		end else if (sh_esc == ESC_GOT && c == CH_LBR) begin
			sh_esc = ESC_BRK;
		end else begin
			sh_esc = ESC_NONE;
			edit_plain(c);
		end
		n_pred = pending_bytes.size() - base;
		if (pending_bytes.size() > base)
			pending_bytes[pending_bytes.size()-1].last = 1'b1;
	endtask

	// Receiver: random stall bursts, one long hold-off on request.
	initial begin
		int burst;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				out_ch.ready <= 1'b0;
				for (int i = 0; i < 300; i++) @(posedge clk);
				rx_hold_req = 1'b0;
				out_ch.ready <= 1'b1;
			end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 13);
				out_ch.ready <= 1'b0;
				for (int i = 1; i < burst; i++) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Checker: compare every accepted result with the oldest expected byte.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte %h", out_ch.out_byte));
			end else begin
				want = pending_bytes.pop_front();
				if (out_ch.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %h, want %h",
						out_ch.out_byte, want.out_byte));
				if (out_ch.to_line !== want.to_line)
					report_mismatch($sformatf("to_line %b, want %b on byte %h",
						out_ch.to_line, want.to_line, want.out_byte));
				if (out_ch.last !== want.last)
					report_mismatch($sformatf("last %b, want %b on byte %h",
						out_ch.last, want.last, want.out_byte));
			end
		end
	end

	// Offer one byte, holding it until accepted; optional idle burst before.
	// Valid stays high after acceptance; the next call drops it only before an idle burst, and drain_idle drops it.
	task automatic send_char(input logic [7:0] c);
		int gap;
		if (!tx_quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 13);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_char <= c;
		do @(posedge clk); while (!in_ch.ready);
		predict_edit(c);
	endtask

	task automatic drain_idle();
		in_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (TAIL_IDLE) @(posedge clk);
	endtask

	task automatic write_echo(input logic e);
		cfg.valid       <= 1'b1;
		cfg.echo_enable <= e;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		sh_echo = e;
	endtask

	// Pick a random input byte, biased toward well-formed editing.
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7: return 8'($urandom_range(32, 126));
			8, 9:   return CH_BS;
			10:     return CH_DEL;
			11:     return CH_CR;
			12, 13, 14: return CH_ESC;
			15:     return CH_LBR;
			16:     return 8'($urandom_range(65, 68));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Directed table: the byte to send, and where easy, the single result byte.
	typedef struct {
		logic [7:0] c;
		bit         fixed;
		logic [7:0] want;
	} stim_row_t;

	stim_row_t directed[] = '{
		'{CH_BS,  1'b1, CH_BEL},   // delete at position 0 rings
		'{CH_ESC, 1'b0, 8'h00},
		'{CH_LBR, 1'b0, 8'h00},
		'{CH_D,   1'b1, CH_BEL},   // left at position 0 rings
		'{CH_ESC, 1'b0, 8'h00},
		'{CH_LBR, 1'b0, 8'h00},
		'{CH_C,   1'b1, CH_BEL},   // right at the end rings
		'{CH_ESC, 1'b0, 8'h00},
		'{CH_LBR, 1'b0, 8'h00},
		'{CH_A,   1'b0, 8'h00},    // recall; the history is empty on the first pass
		'{CH_CR,  1'b0, 8'h00},    // enter; the line is empty on the first pass
		'{8'h20,  1'b0, 8'h00},
		'{8'h7E,  1'b0, 8'h00},
		'{8'h00,  1'b0, 8'h00},    // ignored control byte
		'{8'hFF,  1'b0, 8'h00},    // ignored high byte
		'{CH_ESC, 1'b0, 8'h00},
		'{8'h41,  1'b0, 8'h00},    // ESC then a plain byte: inserted
		'{CH_ESC, 1'b0, 8'h00},
		'{CH_LBR, 1'b0, 8'h00},
		'{CH_D,   1'b0, 8'h00},
		'{8'h5A,  1'b0, 8'h00},    // mid-line insert
		'{CH_DEL, 1'b0, 8'h00},    // mid-line delete
		'{CH_ESC, 1'b0, 8'h00},
		'{CH_LBR, 1'b0, 8'h00},
		'{8'h42,  1'b0, 8'h00}     // 'B' after ESC [ does nothing
	};

	initial begin
		arst_n          = 1'b0;
		cfg.valid       = 1'b0;
		cfg.echo_enable = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.in_char   = 8'h00;
		rx_quiet        = 1'b0;
		rx_hold_req     = 1'b0;
		tx_quiet        = 1'b0;
		mismatches      = 0;
		n_pred          = 0;
		sh_esc = ESC_NONE;
		sh_len = 0; sh_cur = 0; sh_hist_len = 0; sh_echo = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass twice: echo off, then echo on.
		for (int pass = 0; pass < 2; pass++) begin
			write_echo(pass[0]);
			foreach (directed[i]) begin
				send_char(directed[i].c);
				if (directed[i].fixed && (n_pred != 1 ||
						pending_bytes[pending_bytes.size()-1].out_byte != directed[i].want))
					report_mismatch($sformatf("directed row %0d expectation", i));
			end
			// Fill the line past capacity, then recall the full line.
			for (int i = 0; i < LINE_CAP + 2; i++) send_char(8'($urandom_range(32, 126)));
			send_char(CH_CR);
			send_char(CH_ESC); send_char(CH_LBR); send_char(CH_A);
			send_char(CH_ESC); send_char(CH_LBR); send_char(CH_D);
			send_char(CH_BS);
			// Clear the line so the next pass starts at position 0.
			send_char(CH_CR);
			drain_idle();
		end

		// Hold off the receiver while offering long results, so input stalls.
		rx_hold_req = 1'b1;
		for (int i = 0; i < 10; i++) begin
			send_char(CH_ESC); send_char(CH_LBR); send_char(CH_A);
		end
		drain_idle();

		// Random part in phases of changing echo setting; the last one quiet.
		for (int ph = 0; ph < 4; ph++) begin
			write_echo(ph == 3 ? 1'b1 : 1'($urandom_range(0, 1)));
			if (ph == 3) begin
				rx_quiet = 1'b1;
				tx_quiet = 1'b1;
			end
			for (int i = 0; i < N_RANDOM / 4; i++) send_char(pick_char());
			drain_idle();
		end

		if (mismatches == 0)
			$display("tb_terminal_line_editor_unit passed");
		else
			$display("tb_terminal_line_editor_unit failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_terminal_line_editor_unit failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tle_pkg.sv
rtl/tle_if.sv
rtl/tle_out_reg.sv
rtl/terminal_line_editor_unit.sv
rtl/tle_checker.sv
sim/tb_terminal_line_editor_unit.sv
